// File: hw/rtl/anxb_pkg.sv
package anxb_pkg;

    // Width of stream offsets and NAL lengths
    localparam int OFFSET_BITS = 32;
    localparam int UNIT_BITS   = 32;
    localparam int KIND_BITS   = 6;

    // Record queue between scanner and grouper
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Output word layout
    localparam int OUT_FIELDS_W = 2 * OFFSET_BITS + 3 + KIND_BITS + UNIT_BITS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // NAL unit type codes
    localparam logic [KIND_BITS-1:0] H264_KIND_SLICE = 6'd1;
    localparam logic [KIND_BITS-1:0] H264_KIND_IDR   = 6'd5;
    localparam logic [KIND_BITS-1:0] H264_KIND_AUD   = 6'd9;
    localparam logic [KIND_BITS-1:0] H265_KIND_AUD   = 6'd35;
    localparam logic [KIND_BITS-1:0] H265_VCL_LAST   = 6'd31;

    // Raw NAL record as produced by the scanner
    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic                   four;
        logic                   hdr_ok;
        logic [7:0]             hdr;
        logic                   fin;
    } nal_rec_t;

    // Up to two records per accepted byte; rec0 is the older one
    typedef struct packed {
        logic [1:0] vld;
        nal_rec_t   rec0;
        nal_rec_t   rec1;
    } nal_push_t;

endpackage

// File: hw/rtl/anxb_scanner.sv
module anxb_scanner
    import anxb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       q_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output nal_push_t  push
);

    logic [1:0]             zero_run_reg, zero_run_next;
    logic [1:0]             head_cnt_reg, head_cnt_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   inside_reg, inside_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic                   four_reg, four_next;
    logic [7:0]             hdr_reg, hdr_next;
    logic [2:0]             tail_reg, tail_next;

    logic                   accept;
    logic                   code;
    logic                   code_four;
    logic [1:0]             zc;
    logic [OFFSET_BITS-1:0] code_start;
    logic                   upd_inside;
    logic [OFFSET_BITS-1:0] upd_start;
    logic                   upd_four;
    logic [7:0]             upd_hdr;
    logic [2:0]             upd_tail;
    logic [1:0]             upd_zero_run;
    logic [1:0]             upd_head_cnt;

    assign accept = byte_valid && q_ready;

    always_comb
    begin
        code_four  = (zero_run_reg == 2'd3);
        code       = (data_byte == 8'h01) &&
                     (code_four || ((zero_run_reg == 2'd2) && (head_cnt_reg == 2'd3) &&
                                    !end_of_stream));
        zc         = code_four ? 2'd3 : 2'd2;
        code_start = pos_reg - OFFSET_BITS'(zc);

        upd_inside = inside_reg;
        upd_start  = start_reg;
        upd_four   = four_reg;
        upd_hdr    = hdr_reg;
        upd_tail   = tail_reg;
        if (code)
        begin
            upd_inside = 1'b1;
            upd_start  = code_start;
            upd_four   = code_four;
            upd_hdr    = 8'h00;
            upd_tail   = 3'd0;
        end
        else if (inside_reg)
        begin
            if (tail_reg == 3'd0)
                upd_hdr = data_byte;
            if (tail_reg < 3'd4)
                upd_tail = tail_reg + 3'd1;
        end

        if (data_byte == 8'h00)
            upd_zero_run = (zero_run_reg == 2'd3) ? 2'd3 : zero_run_reg + 2'd1;
        else
            upd_zero_run = 2'd0;
        upd_head_cnt = (head_cnt_reg == 2'd3) ? 2'd3 : head_cnt_reg + 2'd1;

        // previous NAL closed by a new start code
        push.vld[0]       = accept && code && inside_reg;
        push.rec0.start   = start_reg;
        push.rec0.len     = code_start - start_reg;
        push.rec0.four    = four_reg;
        push.rec0.hdr_ok  = (tail_reg > 3'(zc));
        push.rec0.hdr     = hdr_reg;
        push.rec0.fin     = 1'b0;

        // NAL closed by end of stream
        push.vld[1]       = accept && end_of_stream && upd_inside;
        push.rec1.start   = upd_start;
        push.rec1.len     = pos_reg + OFFSET_BITS'(1) - upd_start;
        push.rec1.four    = upd_four;
        push.rec1.hdr_ok  = (upd_tail != 3'd0);
        push.rec1.hdr     = upd_hdr;
        push.rec1.fin     = 1'b1;

        zero_run_next = zero_run_reg;
        head_cnt_next = head_cnt_reg;
        pos_next      = pos_reg;
        inside_next   = inside_reg;
        start_next    = start_reg;
        four_next     = four_reg;
        hdr_next      = hdr_reg;
        tail_next     = tail_reg;
        if (accept)
        begin
            if (end_of_stream)
            begin
                zero_run_next = 2'd0;
                head_cnt_next = 2'd0;
                pos_next      = '0;
                inside_next   = 1'b0;
                start_next    = '0;
                four_next     = 1'b0;
                hdr_next      = 8'h00;
                tail_next     = 3'd0;
            end
            else
            begin
                zero_run_next = upd_zero_run;
                head_cnt_next = upd_head_cnt;
                pos_next      = pos_reg + OFFSET_BITS'(1);
                inside_next   = upd_inside;
                start_next    = upd_start;
                four_next     = upd_four;
                hdr_next      = upd_hdr;
                tail_next     = upd_tail;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= 2'd0;
            head_cnt_reg <= 2'd0;
            pos_reg      <= '0;
            inside_reg   <= 1'b0;
            start_reg    <= '0;
            four_reg     <= 1'b0;
            hdr_reg      <= 8'h00;
            tail_reg     <= 3'd0;
        end
        else
        begin
            zero_run_reg <= zero_run_next;
            head_cnt_reg <= head_cnt_next;
            pos_reg      <= pos_next;
            inside_reg   <= inside_next;
            start_reg    <= start_next;
            four_reg     <= four_next;
            hdr_reg      <= hdr_next;
            tail_reg     <= tail_next;
        end
    end

endmodule

// File: hw/rtl/anxb_queue.sv
module anxb_queue
    import anxb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  nal_push_t         push,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output nal_rec_t          head,
    output logic [QCNT_W-1:0] level
);

    nal_rec_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    logic [1:0]          n_push;
    logic                do_pop;
    nal_rec_t            wdata0;

    assign push_ready = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign level      = cnt_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        n_push      = {1'b0, push.vld[0]} + {1'b0, push.vld[1]};
        // first present record goes to the write pointer
        wdata0      = push.vld[0] ? push.rec0 : push.rec1;
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
        cnt_next    = cnt_reg + QCNT_W'(n_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            slot_reg[wr_ptr_reg] <= wdata0;
        if (n_push == 2'd2)
            slot_reg[wr_ptr_reg + QPTR_W'(1)] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/anxb_grouper.sv
module anxb_grouper
    import anxb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   codec_is_h265,
    input  logic                   head_valid,
    input  nal_rec_t               head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data,
    output logic                   out_last
);

    logic                   has_vcl_reg, has_vcl_next;
    logic                   unit_open_reg, unit_open_next;
    logic [UNIT_BITS-1:0]   unit_cnt_reg, unit_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic [KIND_BITS-1:0]   kind;
    logic                   is_aud;
    logic                   is_vcl;
    logic                   fresh;
    logic                   opens;
    logic                   bump;
    logic [UNIT_BITS-1:0]   cnt_upd;
    logic                   vcl_upd;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        if (!head.hdr_ok)
            kind = '0;
        else if (codec_is_h265)
            kind = head.hdr[6:1];
        else
            kind = {1'b0, head.hdr[4:0]};

        is_aud = head.hdr_ok && (kind == (codec_is_h265 ? H265_KIND_AUD : H264_KIND_AUD));
        is_vcl = head.hdr_ok &&
                 (codec_is_h265 ? (kind <= H265_VCL_LAST)
                                : ((kind == H264_KIND_SLICE) || (kind == H264_KIND_IDR)));
        fresh  = is_aud || (is_vcl && has_vcl_reg);
        opens  = fresh || !unit_open_reg;
        bump   = fresh && unit_open_reg;

        cnt_upd = bump ? unit_cnt_reg + UNIT_BITS'(1) : unit_cnt_reg;
        vcl_upd = is_vcl || (has_vcl_reg && !bump);

        has_vcl_next   = has_vcl_reg;
        unit_open_next = unit_open_reg;
        unit_cnt_next  = unit_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{OUT_PAD_W{1'b0}}, cnt_upd, opens, kind, head.hdr_ok,
                              head.four, head.len, head.start};
            out_last_next  = head.fin;
            if (head.fin)
            begin
                // stream over: grouping starts afresh
                has_vcl_next   = 1'b0;
                unit_open_next = 1'b0;
                unit_cnt_next  = '0;
            end
            else
            begin
                has_vcl_next   = vcl_upd;
                unit_open_next = 1'b1;
                unit_cnt_next  = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_vcl_reg   <= 1'b0;
            unit_open_reg <= 1'b0;
            unit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            has_vcl_reg   <= has_vcl_next;
            unit_open_reg <= unit_open_next;
            unit_cnt_reg  <= unit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/annexb_nal_splitter_au_grouper_unit.sv
// Channel   Dir  Width  Word contents
// s_axis    in   8+1    tdata: data_byte; tlast: end_of_stream
// m_axis    out  112+1  tdata: NAL record fields; tlast: final_record
// cfg       in   1      codec_is_h265 write (cfg_wen / cfg_wdata)
//
// One byte per clock is accepted while ready; each byte is scanned in the cycle it
// is accepted and its records enter the queue at that same edge. A record is popped
// at the next edge at the earliest and shows on m_axis right after that edge.
// Output runs at one record per clock unless stalled, set by the grouper's single
// output register; a byte ending a NAL and the stream at once queues two records.
// s_axis_tready drops while the 4-entry record queue has fewer than two free slots.
// Reset clears all stream state, the queue and codec_is_h265; payload is not reset.
module annexb_nal_splitter_au_grouper_unit
    import anxb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wen,
    input  logic                   cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,   // end_of_stream

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] nal_offset, [63:32] nal_length, [64] start_code_four,
    // [65] type_valid, [71:66] nal_kind, [72] opens_access_unit,
    // [104:73] unit_number, [111:105] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast    // final_record
);

    logic              codec_reg, codec_next;

    nal_push_t         push;
    logic              q_ready;
    logic              q_pop;
    logic              q_valid;
    nal_rec_t          q_head;
    logic [QCNT_W-1:0] q_level;

    assign codec_next    = cfg_wen ? cfg_wdata : codec_reg;
    assign s_axis_tready = q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            codec_reg <= 1'b0;
        else
            codec_reg <= codec_next;
    end

    // Front: start code detection and NAL boundaries
    anxb_scanner u_scanner
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (s_axis_tvalid),
        .q_ready       (q_ready),
        .data_byte     (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .push          (push)
    );

    // Decouples scanner from output back-pressure
    anxb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head),
        .level      (q_level)
    );

    // Back: type classification, access-unit grouping, output register
    anxb_grouper u_grouper
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .codec_is_h265 (codec_reg),
        .head_valid    (q_valid),
        .head          (q_head),
        .pop           (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata),
        .out_last      (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= QCNT_W'(QDEPTH))
        else $error("record queue overflow");

    // two records only when there is room for both
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.vld == 2'b11) |-> (q_level <= QCNT_W'(QDEPTH - 2)))
        else $error("double push without room");

    // no header byte means type code zero
    a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[65]) |-> (m_axis_tdata[71:66] == '0))
        else $error("nal_kind set without header");

    // the queue only pops when it has a record
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_level != '0))
        else $error("pop from empty queue");
`endif

endmodule
